// File: hdl/qbp_pkg.sv
// ============================================================================
// qbp_pkg
// Shared types, constants and the Bernstein weight function for the quartic
// Bezier polyline generator.
// ============================================================================
package qbp_pkg;

   // 8.8 fixed point: one fractional byte
   localparam int FRAC_BITS   = 8;
   localparam int ONE_FIXED   = 256;
   // quartic curve: five control points
   localparam int NUM_CTRL    = 5;
   // a truncated weight never exceeds 256
   localparam int WEIGHT_BITS = 9;

   typedef logic [WEIGHT_BITS-1:0] weight_type;

   // control bits that travel with each segment down the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } stage_ctrl_type;

   // Bernstein weight k at parameter t, truncating after every fixed-point product
   function automatic weight_type bez_weight(input int t, input int k);
      int t2, t3, t4, mt, mt2, mt3, mt4, w;
      t2  = (t * t) >> FRAC_BITS;
      t3  = (t2 * t) >> FRAC_BITS;
      t4  = (t3 * t) >> FRAC_BITS;
      mt  = ONE_FIXED - t;
      mt2 = (mt * mt) >> FRAC_BITS;
      mt3 = (mt2 * mt) >> FRAC_BITS;
      mt4 = (mt3 * mt) >> FRAC_BITS;
      case (k)
         0:       w = mt4;
         1:       w = 4 * ((mt3 * t) >> FRAC_BITS);
         2:       w = 6 * ((mt2 * t2) >> FRAC_BITS);
         3:       w = 4 * ((mt * t3) >> FRAC_BITS);
         default: w = t4;
      endcase
      return weight_type'(w);
   endfunction

endpackage

// File: hdl/quartic_bezier_polyline.sv
// Each curve transaction on the request side (five control points) produces
// SEGMENTS + 1 segment transactions on the response side: the SEGMENTS chords
// of the sampled curve starting at P0, then a closing segment back to P0 with
// rsp_tlast high. A sequencer issues one segment per cycle, unless the
// response side stalls, into a four-stage pipeline (weight lookup, multiply,
// sum, output register), so a curve issues SEGMENTS + 1 segments and the
// next curve is taken in the cycle its last segment issues. An accepted curve
// is registered in the sequencer before its segments enter the pipeline. A
// stall on the response side freezes the whole pipeline.
// ============================================================================
// quartic_bezier_polyline
// Quartic Bezier curve to closed polyline, 1.8 fixed-point Bernstein weights.
// ============================================================================
module quartic_bezier_polyline #(
   parameter int SEGMENTS   = 14,
   parameter int COORD_BITS = 10,
   localparam int REQ_W     = ((10 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W     = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // seg_x_start, seg_y_start, seg_x_end, seg_y_end, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   // last_segment
   output logic             rsp_tlast
);
   import qbp_pkg::*;

   localparam int CNT_W  = $clog2(SEGMENTS + 2);
   localparam int TBL_N  = SEGMENTS + 2;
   localparam int PROD_W = COORD_BITS + WEIGHT_BITS;
   localparam int SUM_W  = PROD_W + 3;
   localparam logic [CNT_W-1:0] FIRST_IDX = CNT_W'(1);
   localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(SEGMENTS + 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   // ------------------------------------------------------------------
   // constant weight table, one row per segment index
   // ------------------------------------------------------------------
   weight_type wt_table [TBL_N][NUM_CTRL];

   for (genvar g = 0; g < TBL_N; g++) begin : g_row
      localparam int TV = (g * ONE_FIXED) / SEGMENTS;
      for (genvar k = 0; k < NUM_CTRL; k++) begin : g_col
         if (g >= 1 && g <= SEGMENTS) begin : g_used
            assign wt_table[g][k] = bez_weight(TV, k);
         end else begin : g_zero
            assign wt_table[g][k] = '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // pipeline enable: move everything unless the output is stuck
   // ------------------------------------------------------------------
   logic advance;
   assign advance = rsp_tready || !rsp_tvalid;

   // ------------------------------------------------------------------
   // sequencer: hold the curve and, while the pipeline advances, issue one segment index per cycle
   // ------------------------------------------------------------------
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   coord_type        cx_ff [NUM_CTRL];
   coord_type        cy_ff [NUM_CTRL];
   logic             req_take;

   assign req_tready = advance && (!busy_ff || seg_cnt_ff == LAST_IDX);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      busy_in    = busy_ff;
      seg_cnt_in = seg_cnt_ff;
      if (busy_ff && advance) begin
         if (seg_cnt_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            seg_cnt_in = seg_cnt_ff + CNT_W'(1);
         end
      end
      if (req_take) begin
         busy_in    = 1'b1;
         seg_cnt_in = FIRST_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         seg_cnt_ff <= FIRST_IDX;
      end else begin
         busy_ff    <= busy_in;
         seg_cnt_ff <= seg_cnt_in;
      end
   end

   // capture the control points of an accepted curve
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int k = 0; k < NUM_CTRL; k++) begin
            cx_ff[k] <= req_tdata[(2 * k) * COORD_BITS +: COORD_BITS];
            cy_ff[k] <= req_tdata[(2 * k + 1) * COORD_BITS +: COORD_BITS];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 1: weight lookup
   // ------------------------------------------------------------------
   stage_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   weight_type     s1_w_ff  [NUM_CTRL];
   coord_type      s1_cx_ff [NUM_CTRL];
   coord_type      s1_cy_ff [NUM_CTRL];

   always_comb begin
      s1_ctrl_in.valid = busy_ff;
      s1_ctrl_in.first = (seg_cnt_ff == FIRST_IDX);
      s1_ctrl_in.last  = (seg_cnt_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else if (advance) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_CTRL; k++) begin
            s1_w_ff[k]  <= wt_table[seg_cnt_ff][k];
            s1_cx_ff[k] <= cx_ff[k];
            s1_cy_ff[k] <= cy_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: weight times control point
   // ------------------------------------------------------------------
   stage_ctrl_type    s2_ctrl_ff;
   logic [PROD_W-1:0] s2_px_ff [NUM_CTRL];
   logic [PROD_W-1:0] s2_py_ff [NUM_CTRL];
   logic [PROD_W-1:0] s2_px_in [NUM_CTRL];
   logic [PROD_W-1:0] s2_py_in [NUM_CTRL];
   coord_type         s2_p0x_ff, s2_p0y_ff;

   always_comb begin
      for (int k = 0; k < NUM_CTRL; k++) begin
         s2_px_in[k] = PROD_W'(s1_cx_ff[k]) * PROD_W'(s1_w_ff[k]);
         s2_py_in[k] = PROD_W'(s1_cy_ff[k]) * PROD_W'(s1_w_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (advance) begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_px_ff  <= s2_px_in;
         s2_py_ff  <= s2_py_in;
         s2_p0x_ff <= s1_cx_ff[0];
         s2_p0y_ff <= s1_cy_ff[0];
      end
   end

   // ------------------------------------------------------------------
   // stage 3: sum the products and drop the fraction
   // ------------------------------------------------------------------
   stage_ctrl_type   s3_ctrl_ff;
   coord_type        s3_x_ff, s3_y_ff, s3_p0x_ff, s3_p0y_ff;
   logic [SUM_W-1:0] sum_x, sum_y;

   always_comb begin
      sum_x = '0;
      sum_y = '0;
      for (int k = 0; k < NUM_CTRL; k++) begin
         sum_x = sum_x + SUM_W'(s2_px_ff[k]);
         sum_y = sum_y + SUM_W'(s2_py_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else if (advance) begin
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_x_ff   <= sum_x[FRAC_BITS +: COORD_BITS];
         s3_y_ff   <= sum_y[FRAC_BITS +: COORD_BITS];
         s3_p0x_ff <= s2_p0x_ff;
         s3_p0y_ff <= s2_p0y_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register: chain from the previous point, close back to P0
   // ------------------------------------------------------------------
   logic      rsp_valid_ff;
   logic      rsp_last_ff;
   coord_type xs_ff, ys_ff, xe_ff, ye_ff;
   coord_type xs_in, ys_in, xe_in, ye_in;
   coord_type prev_x_ff, prev_y_ff;

   always_comb begin
      xs_in = s3_ctrl_ff.first ? s3_p0x_ff : prev_x_ff;
      ys_in = s3_ctrl_ff.first ? s3_p0y_ff : prev_y_ff;
      xe_in = s3_ctrl_ff.last  ? s3_p0x_ff : s3_x_ff;
      ye_in = s3_ctrl_ff.last  ? s3_p0y_ff : s3_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_ctrl_ff.valid) begin
         xs_ff       <= xs_in;
         ys_ff       <= ys_in;
         xe_ff       <= xe_in;
         ye_ff       <= ye_in;
         rsp_last_ff <= s3_ctrl_ff.last;
         prev_x_ff   <= xe_in;
         prev_y_ff   <= ye_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0 * COORD_BITS +: COORD_BITS] = xs_ff;
      rsp_tdata[1 * COORD_BITS +: COORD_BITS] = ys_ff;
      rsp_tdata[2 * COORD_BITS +: COORD_BITS] = xe_ff;
      rsp_tdata[3 * COORD_BITS +: COORD_BITS] = ye_ff;
   end

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_take_restarts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (busy_ff && seg_cnt_ff == FIRST_IDX))
      else $error("accepted curve did not restart the sequencer");

   a_stall_holds_seq: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !advance) |=> (busy_ff && $stable(seg_cnt_ff)))
      else $error("sequencer moved during a stall");

   a_close_zero_weight: assert property (@(posedge clock) disable iff (reset)
      (s1_ctrl_ff.valid && s1_ctrl_ff.last) |->
         (s1_w_ff[0] == '0 && s1_w_ff[4] == '0))
      else $error("closing segment carries nonzero weights");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s3_ctrl_ff) && $stable(s2_ctrl_ff)))
      else $error("pipeline moved during a stall");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the quartic Bezier polyline generator: sends curve
// transactions, predicts every segment in 8.8 fixed point and compares each
// segment transaction field by field, under random idling on both sides.
// ============================================================================
module tb;
   import qbp_pkg::*;

   localparam int SEGMENTS    = 14;
   localparam int COORD_BITS  = 10;
   localparam int REQ_W       = ((10 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int RANDOM_CURVES = 253;
   localparam int STALL_CYCLES  = 200;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 1_500_000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [NUM_CTRL-1:0][COORD_BITS-1:0] x;
      logic [NUM_CTRL-1:0][COORD_BITS-1:0] y;
   } curve_type;

   typedef struct packed {
      logic      last;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } segment_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   segment_type pending_segments[$];
   int          mismatches    = 0;
   int          cycle_count   = 0;
   bit          stall_request = 1'b0;
   segment_type seen_segment;
   segment_type want_segment;

   quartic_bezier_polyline #(
      .SEGMENTS   (SEGMENTS),
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[quartic_bezier_polyline] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("t=%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   // Sample the curve, chain the chords from P0 and close back to P0
   function automatic void trace_polyline(input curve_type c);
      int          t, t2, t3, t4, mt, mt2, mt3, mt4;
      int          w[NUM_CTRL];
      int          acc_x, acc_y;
      coord_type   px, py, nx, ny;
      segment_type s;
      px = c.x[0];
      py = c.y[0];
      for (int i = 1; i <= SEGMENTS; i++) begin
         t   = (i * ONE_FIXED) / SEGMENTS;
         t2  = (t * t) >> FRAC_BITS;
         t3  = (t2 * t) >> FRAC_BITS;
         t4  = (t3 * t) >> FRAC_BITS;
         mt  = ONE_FIXED - t;
         mt2 = (mt * mt) >> FRAC_BITS;
         mt3 = (mt2 * mt) >> FRAC_BITS;
         mt4 = (mt3 * mt) >> FRAC_BITS;
         w[0] = mt4;
         w[1] = 4 * ((mt3 * t) >> FRAC_BITS);
         w[2] = 6 * ((mt2 * t2) >> FRAC_BITS);
         w[3] = 4 * ((mt * t3) >> FRAC_BITS);
         w[4] = t4;
         acc_x = 0;
         acc_y = 0;
         for (int k = 0; k < NUM_CTRL; k++) begin
            acc_x += w[k] * int'(c.x[k]);
            acc_y += w[k] * int'(c.y[k]);
         end
         nx = acc_x[FRAC_BITS +: COORD_BITS];
         ny = acc_y[FRAC_BITS +: COORD_BITS];
         s.last    = 1'b0;
         s.x_start = px;
         s.y_start = py;
         s.x_end   = nx;
         s.y_end   = ny;
         pending_segments.push_back(s);
         px = nx;
         py = ny;
      end
      s.last    = 1'b1;
      s.x_start = px;
      s.y_start = py;
      s.x_end   = c.x[0];
      s.y_end   = c.y[0];
      pending_segments.push_back(s);
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one curve transaction after an idle gap, hold until accepted
   task automatic send_curve(input curve_type c, input int gap);
      logic [REQ_W-1:0] packed_points;
      packed_points = '0;
      for (int k = 0; k < NUM_CTRL; k++) begin
         packed_points[(2 * k) * COORD_BITS +: COORD_BITS]     = c.x[k];
         packed_points[(2 * k + 1) * COORD_BITS +: COORD_BITS] = c.y[k];
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= packed_points;
      do @(posedge clock); while (!req_tready);
      trace_polyline(c);
   endtask

   function automatic curve_type flat_curve(input int xv, input int yv);
      curve_type c;
      for (int k = 0; k < NUM_CTRL; k++) begin
         c.x[k] = coord_type'(xv);
         c.y[k] = coord_type'(yv);
      end
      return c;
   endfunction

   function automatic coord_type random_coord(input int style);
      int r;
      if (style == 0) return coord_type'($urandom_range(0, COORD_MAX));
      r = $urandom_range(0, 3);
      if (r == 0) return '0;
      if (r == 1) return coord_type'(COORD_MAX);
      return coord_type'($urandom_range(0, COORD_MAX));
   endfunction

   // Drive the response ready: random runs and gaps, plus a requested long hold
   initial begin
      int run_len;
      int gap;
      @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Compare each segment transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_segment.x_start = rsp_tdata[0 +: COORD_BITS];
         seen_segment.y_start = rsp_tdata[COORD_BITS +: COORD_BITS];
         seen_segment.x_end   = rsp_tdata[2 * COORD_BITS +: COORD_BITS];
         seen_segment.y_end   = rsp_tdata[3 * COORD_BITS +: COORD_BITS];
         seen_segment.last    = rsp_tlast;
         if (pending_segments.size() == 0) begin
            report_mismatch("segment with none pending", seen_segment.x_start, -1);
         end else begin
            want_segment = pending_segments.pop_front();
            if (seen_segment.x_start !== want_segment.x_start)
               report_mismatch("seg_x_start", seen_segment.x_start, want_segment.x_start);
            if (seen_segment.y_start !== want_segment.y_start)
               report_mismatch("seg_y_start", seen_segment.y_start, want_segment.y_start);
            if (seen_segment.x_end !== want_segment.x_end)
               report_mismatch("seg_x_end", seen_segment.x_end, want_segment.x_end);
            if (seen_segment.y_end !== want_segment.y_end)
               report_mismatch("seg_y_end", seen_segment.y_end, want_segment.y_end);
            if (seen_segment.last !== want_segment.last)
               report_mismatch("last_segment", seen_segment.last, want_segment.last);
         end
      end
   end

   // Flat curves at the coordinate extremes and alternating bit patterns,
   // a full-scale step between P0 and the rest, and a spike on each point
   task automatic test_extremes();
      int        patterns[4];
      curve_type c;
      patterns = '{0, COORD_MAX, 'h2AA, 'h155};
      foreach (patterns[n]) begin
         send_curve(flat_curve(patterns[n], patterns[n]), pick_gap());
         send_curve(flat_curve(patterns[n], COORD_MAX - patterns[n]), pick_gap());
      end
      c = flat_curve(0, 0);
      c.x[0] = coord_type'(COORD_MAX);
      c.y[0] = coord_type'(COORD_MAX);
      send_curve(c, pick_gap());
      c = flat_curve(COORD_MAX, COORD_MAX);
      c.x[0] = '0;
      c.y[0] = '0;
      send_curve(c, pick_gap());
      for (int k = 0; k < NUM_CTRL; k++) begin
         c = flat_curve(0, COORD_MAX);
         c.x[k] = coord_type'(COORD_MAX);
         c.y[k] = '0;
         send_curve(c, pick_gap());
      end
   endtask

   // The last sampled point must land exactly on P4
   task automatic test_curve_end();
      curve_type c;
      for (int n = 0; n < 4; n++) begin
         c = flat_curve((n % 2) ? COORD_MAX : 0, (n % 2) ? 0 : COORD_MAX);
         c.x[4] = random_coord(0);
         c.y[4] = random_coord(0);
         send_curve(c, pick_gap());
      end
   endtask

   // Hold the response side while curves keep coming, so the input stalls
   task automatic test_backpressure();
      curve_type c;
      stall_request = 1'b1;
      for (int n = 0; n < 8; n++) begin
         for (int k = 0; k < NUM_CTRL; k++) begin
            c.x[k] = random_coord(0);
            c.y[k] = random_coord(0);
         end
         send_curve(c, 0);
      end
   endtask

   // Random curves, with back-to-back bursts and occasional degenerate shapes
   task automatic test_random();
      curve_type c;
      int        burst_left;
      int        style;
      int        gap;
      burst_left = 0;
      for (int n = 0; n < RANDOM_CURVES; n++) begin
         style = $urandom_range(0, 9);
         if (style == 0) begin
            c = flat_curve($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         end else begin
            for (int k = 0; k < NUM_CTRL; k++) begin
               c.x[k] = random_coord(style == 1);
               c.y[k] = random_coord(style == 1);
            end
         end
         if (burst_left == 0 && $urandom_range(0, 19) == 0)
            burst_left = $urandom_range(5, 15);
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else begin
            gap = pick_gap();
         end
         send_curve(c, gap);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_curve_end();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[quartic_bezier_polyline] OK");
      else
         $display("[quartic_bezier_polyline] ERROR");
      $finish;
   end

endmodule

// File: sim.f
hdl/qbp_pkg.sv
hdl/quartic_bezier_polyline.sv
bench/tb.sv
